[hw/rtl/stl_pkg.sv]
// Shared types and codes for the script token lexer.
package stl_pkg;

  // Result field widths
  localparam int KIND_W  = 6;
  localparam int CAUSE_W = 3;
  localparam int LINE_W  = 16;
  localparam int COL_W   = 16;
  localparam int OFF_W   = 24;
  localparam int LEN_W   = 16;

  // Token kinds
  localparam logic [KIND_W-1:0] TK_END     = 6'd0;
  localparam logic [KIND_W-1:0] TK_INVALID = 6'd1;
  localparam logic [KIND_W-1:0] TK_INT     = 6'd2;
  localparam logic [KIND_W-1:0] TK_IDENT   = 6'd3;
  localparam logic [KIND_W-1:0] TK_STRING  = 6'd4;
  localparam logic [KIND_W-1:0] TK_KW_LET  = 6'd5;
  localparam logic [KIND_W-1:0] TK_ANDAND  = 6'd15;
  localparam logic [KIND_W-1:0] TK_OROR    = 6'd16;
  localparam logic [KIND_W-1:0] TK_EQEQ    = 6'd17;
  localparam logic [KIND_W-1:0] TK_NE      = 6'd18;
  localparam logic [KIND_W-1:0] TK_LE      = 6'd19;
  localparam logic [KIND_W-1:0] TK_GE      = 6'd20;
  localparam logic [KIND_W-1:0] TK_LPAREN  = 6'd21;
  localparam logic [KIND_W-1:0] TK_RPAREN  = 6'd22;
  localparam logic [KIND_W-1:0] TK_LBRACE  = 6'd23;
  localparam logic [KIND_W-1:0] TK_RBRACE  = 6'd24;
  localparam logic [KIND_W-1:0] TK_COMMA   = 6'd25;
  localparam logic [KIND_W-1:0] TK_SEMI    = 6'd26;
  localparam logic [KIND_W-1:0] TK_PLUS    = 6'd27;
  localparam logic [KIND_W-1:0] TK_MINUS   = 6'd28;
  localparam logic [KIND_W-1:0] TK_STAR    = 6'd29;
  localparam logic [KIND_W-1:0] TK_SLASH   = 6'd30;
  localparam logic [KIND_W-1:0] TK_PERCENT = 6'd31;
  localparam logic [KIND_W-1:0] TK_BANG    = 6'd32;
  localparam logic [KIND_W-1:0] TK_ASSIGN  = 6'd33;
  localparam logic [KIND_W-1:0] TK_LT      = 6'd34;
  localparam logic [KIND_W-1:0] TK_GT      = 6'd35;

  // Error causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_OPEN_CMT = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_OPEN_STR = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_OPEN_ESC = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_BAD_ESC  = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_BAD_CHAR = 3'd5;

  typedef enum logic [4:0] {
    MODE_BOM0, MODE_BOM1, MODE_BOM2, MODE_IDLE, MODE_SLASH, MODE_CMT,
    MODE_CSTAR, MODE_NUM, MODE_WORD, MODE_STR, MODE_ESC, MODE_AMP,
    MODE_PIPE, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT
  } lex_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CAUSE_W-1:0] cause;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   col;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    logic               last;
  } tok_t;

  // Up to two results per step; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } step_res_t;

endpackage

[hw/rtl/stl_core.sv]
// Lexer state machine: position counters, token start and one transition per byte.
module stl_core import stl_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 24,
  parameter int LEN_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic        req_type,
  input  logic [7:0]  src_byte,
  output step_res_t   res
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NBSP  = 8'hA0;
  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  localparam int NUM_KW = 10;
  localparam int PFX_BYTES = 6;

  // Keywords, first character in the low byte, zero padded
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'h0000_0074_656C,  // let
    48'h0000_636E_7566,  // func
    48'h6E72_7574_6572,  // return
    48'h0000_0000_6669,  // if
    48'h0000_6573_6C65,  // else
    48'h0065_6C69_6877,  // while
    48'h0000_6575_7274,  // true
    48'h0065_736C_6166,  // false
    48'h0074_6E69_7270,  // print
    48'h0074_7570_6E69   // input
  };

  lex_mode_t              mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt, tok_line_r, tok_line_nxt;
  logic [COL_BITS-1:0]    cur_col_r, cur_col_nxt, tok_col_r, tok_col_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt, tok_off_r, tok_off_nxt;
  logic [LEN_BITS-1:0]    tok_len_r, tok_len_nxt;
  logic [47:0]            prefix_r, prefix_nxt;
  logic                   halted_r, halted_nxt;

  logic [LINE_BITS-1:0]   adv_line;
  logic [COL_BITS-1:0]    adv_col;
  logic [OFFSET_BITS-1:0] adv_off;
  logic [LEN_BITS-1:0]    len_inc;

  logic [LINE_W-1:0] tl_o, cl_o, al_o;
  logic [COL_W-1:0]  tc_o, cc_o, ac_o;
  logic [OFF_W-1:0]  to_o, co_o, ao_o;
  logic [LEN_W-1:0]  tn_o, ti_o;

  logic is_digit, is_wstart, is_wcont, is_space;
  logic [KIND_W-1:0] word_kind;

  lex_mode_t beg_mode;
  logic      beg_emit, beg_err;
  tok_t      beg_tok;

  function automatic tok_t mk(input logic [KIND_W-1:0] kind, input logic [CAUSE_W-1:0] cause,
                              input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] cl,
                              input logic [OFF_W-1:0] of, input logic [LEN_W-1:0] ln_b);
    tok_t t;
    t.kind  = kind;
    t.cause = cause;
    t.line  = ln;
    t.col   = cl;
    t.off   = of;
    t.len   = ln_b;
    t.last  = 1'b0;
    return t;
  endfunction

  // Saturating position advance for the current byte
  assign adv_off  = (&cur_off_r) ? cur_off_r : cur_off_r + OFFSET_BITS'(1);
  assign adv_line = (src_byte != CH_LF) ? cur_line_r :
                    ((&cur_line_r) ? cur_line_r : cur_line_r + LINE_BITS'(1));
  assign adv_col  = (src_byte == CH_LF) ? COL_BITS'(1) :
                    ((&cur_col_r) ? cur_col_r : cur_col_r + COL_BITS'(1));
  assign len_inc  = (&tok_len_r) ? tok_len_r : tok_len_r + LEN_BITS'(1);

  assign tl_o = LINE_W'(tok_line_r);
  assign tc_o = COL_W'(tok_col_r);
  assign to_o = OFF_W'(tok_off_r);
  assign tn_o = LEN_W'(tok_len_r);
  assign ti_o = LEN_W'(len_inc);
  assign cl_o = LINE_W'(cur_line_r);
  assign cc_o = COL_W'(cur_col_r);
  assign co_o = OFF_W'(cur_off_r);
  assign al_o = LINE_W'(adv_line);
  assign ac_o = COL_W'(adv_col);
  assign ao_o = OFF_W'(adv_off);

  assign is_digit  = (src_byte >= 8'h30) && (src_byte <= 8'h39);
  assign is_wstart = ((src_byte >= 8'h61) && (src_byte <= 8'h7A)) ||
                     ((src_byte >= 8'h41) && (src_byte <= 8'h5A)) || (src_byte == CH_USCORE);
  assign is_wcont  = is_wstart || is_digit;
  assign is_space  = (src_byte == CH_SP) || (src_byte == CH_NBSP) ||
                     ((src_byte >= CH_TAB) && (src_byte <= CH_CR));

  always_comb begin
    word_kind = TK_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if ((tok_len_r <= LEN_BITS'(PFX_BYTES)) && (prefix_r == KW_TEXT[i])) begin
        word_kind = TK_KW_LET + KIND_W'(i);
      end
    end
  end

  // What a byte does when it opens a new token
  always_comb begin
    beg_mode = MODE_IDLE;
    beg_emit = 1'b0;
    beg_err  = 1'b0;
    beg_tok  = mk(TK_INVALID, CAUSE_BAD_CHAR, cl_o, cc_o, co_o, '0);
    if (is_space) begin
      beg_mode = MODE_IDLE;
    end else if (is_digit) begin
      beg_mode = MODE_NUM;
    end else if (is_wstart) begin
      beg_mode = MODE_WORD;
    end else begin
      beg_emit = 1'b1;
      case (src_byte)
        CH_SLASH: begin beg_mode = MODE_SLASH; beg_emit = 1'b0; end
        CH_QUOTE: begin beg_mode = MODE_STR;   beg_emit = 1'b0; end
        CH_AMP:   begin beg_mode = MODE_AMP;   beg_emit = 1'b0; end
        CH_PIPE:  begin beg_mode = MODE_PIPE;  beg_emit = 1'b0; end
        CH_EQ:    begin beg_mode = MODE_EQ;    beg_emit = 1'b0; end
        CH_BANG:  begin beg_mode = MODE_BANG;  beg_emit = 1'b0; end
        CH_LT:    begin beg_mode = MODE_LT;    beg_emit = 1'b0; end
        CH_GT:    begin beg_mode = MODE_GT;    beg_emit = 1'b0; end
        CH_LPAR:  beg_tok = mk(TK_LPAREN,  CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_RPAR:  beg_tok = mk(TK_RPAREN,  CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_LBRC:  beg_tok = mk(TK_LBRACE,  CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_RBRC:  beg_tok = mk(TK_RBRACE,  CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_COMMA: beg_tok = mk(TK_COMMA,   CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_SEMI:  beg_tok = mk(TK_SEMI,    CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_PLUS:  beg_tok = mk(TK_PLUS,    CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_MINUS: beg_tok = mk(TK_MINUS,   CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_STAR:  beg_tok = mk(TK_STAR,    CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        CH_PCT:   beg_tok = mk(TK_PERCENT, CAUSE_NONE, cl_o, cc_o, co_o, LEN_W'(1));
        default:  beg_err = 1'b1;
      endcase
    end
  end

  always_comb begin
    logic ev_a, ev_b, do_begin, do_adv;
    tok_t tok_a, tok_b;
    ev_a     = 1'b0;
    ev_b     = 1'b0;
    do_begin = 1'b0;
    do_adv   = 1'b0;
    tok_a    = mk(TK_END, CAUSE_NONE, cl_o, cc_o, co_o, '0);
    tok_b    = tok_a;

    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    cur_off_nxt  = cur_off_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_off_nxt  = tok_off_r;
    tok_len_nxt  = tok_len_r;
    prefix_nxt   = prefix_r;
    halted_nxt   = halted_r;

    if (req_type) begin
      // Flush the pending token, then End at the current position
      if (!halted_r) begin
        ev_a = 1'b1;
        unique case (mode_r)
          MODE_BOM1, MODE_BOM2:
            tok_a = mk(TK_INVALID, CAUSE_BAD_CHAR, LINE_W'(1), COL_W'(1), '0, '0);
          MODE_SLASH: tok_a = mk(TK_SLASH, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_CMT, MODE_CSTAR:
            tok_a = mk(TK_INVALID, CAUSE_OPEN_CMT, tl_o, tc_o, to_o, '0);
          MODE_NUM:   tok_a = mk(TK_INT, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_WORD:  tok_a = mk(word_kind, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_STR:   tok_a = mk(TK_INVALID, CAUSE_OPEN_STR, tl_o, tc_o, to_o, '0);
          MODE_ESC:   tok_a = mk(TK_INVALID, CAUSE_OPEN_ESC, tl_o, tc_o, to_o, '0);
          MODE_AMP, MODE_PIPE:
            tok_a = mk(TK_INVALID, CAUSE_BAD_CHAR, tl_o, tc_o, to_o, '0);
          MODE_EQ:    tok_a = mk(TK_ASSIGN, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_BANG:  tok_a = mk(TK_BANG, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_LT:    tok_a = mk(TK_LT, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          MODE_GT:    tok_a = mk(TK_GT, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
          default:    ev_a = 1'b0;
        endcase
      end
      ev_b  = 1'b1;
      tok_b = mk(TK_END, CAUSE_NONE, cl_o, cc_o, co_o, '0);
      // Rearm
      mode_nxt     = MODE_BOM0;
      cur_line_nxt = LINE_BITS'(1);
      cur_col_nxt  = COL_BITS'(1);
      cur_off_nxt  = '0;
      tok_line_nxt = LINE_BITS'(1);
      tok_col_nxt  = COL_BITS'(1);
      tok_off_nxt  = '0;
      tok_len_nxt  = '0;
      prefix_nxt   = '0;
      halted_nxt   = 1'b0;
    end else if (!halted_r) begin
      unique case (mode_r)
        MODE_BOM0: begin
          if (src_byte == CH_BOM0) mode_nxt = MODE_BOM1;
          else do_begin = 1'b1;
        end
        MODE_BOM1, MODE_BOM2: begin
          if ((mode_r == MODE_BOM1 && src_byte == CH_BOM1) ||
              (mode_r == MODE_BOM2 && src_byte == CH_BOM2)) begin
            mode_nxt = (mode_r == MODE_BOM1) ? MODE_BOM2 : MODE_IDLE;
          end else begin
            ev_a       = 1'b1;
            tok_a      = mk(TK_INVALID, CAUSE_BAD_CHAR, LINE_W'(1), COL_W'(1), '0, '0);
            halted_nxt = 1'b1;
            mode_nxt   = MODE_IDLE;
          end
        end
        MODE_SLASH: begin
          if (src_byte == CH_STAR) begin
            mode_nxt = MODE_CMT;
            do_adv   = 1'b1;
          end else begin
            ev_a     = 1'b1;
            tok_a    = mk(TK_SLASH, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
            do_begin = 1'b1;
          end
        end
        MODE_CMT: begin
          if (src_byte == CH_STAR) mode_nxt = MODE_CSTAR;
          do_adv = 1'b1;
        end
        MODE_CSTAR: begin
          if (src_byte == CH_SLASH) mode_nxt = MODE_IDLE;
          else if (src_byte != CH_STAR) mode_nxt = MODE_CMT;
          do_adv = 1'b1;
        end
        MODE_NUM: begin
          if (is_digit) begin
            tok_len_nxt = len_inc;
            do_adv      = 1'b1;
          end else begin
            ev_a     = 1'b1;
            tok_a    = mk(TK_INT, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
            do_begin = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_wcont) begin
            // Keep the first six bytes for the keyword compare
            if (tok_len_r < LEN_BITS'(PFX_BYTES)) begin
              prefix_nxt = prefix_r | (48'(src_byte) << {tok_len_r[2:0], 3'b000});
            end
            tok_len_nxt = len_inc;
            do_adv      = 1'b1;
          end else begin
            ev_a     = 1'b1;
            tok_a    = mk(word_kind, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
            do_begin = 1'b1;
          end
        end
        MODE_STR: begin
          if (src_byte == CH_LF || src_byte == CH_CR) begin
            ev_a       = 1'b1;
            tok_a      = mk(TK_INVALID, CAUSE_OPEN_STR, tl_o, tc_o, to_o, '0);
            halted_nxt = 1'b1;
            mode_nxt   = MODE_IDLE;
          end else begin
            tok_len_nxt = len_inc;
            do_adv      = 1'b1;
            if (src_byte == CH_QUOTE) begin
              ev_a     = 1'b1;
              tok_a    = mk(TK_STRING, CAUSE_NONE, tl_o, tc_o, to_o, ti_o);
              mode_nxt = MODE_IDLE;
            end else if (src_byte == CH_BSL) begin
              mode_nxt = MODE_ESC;
            end
          end
        end
        MODE_ESC: begin
          tok_len_nxt = len_inc;
          do_adv      = 1'b1;
          if (src_byte == CH_QUOTE || src_byte == CH_BSL || src_byte == CH_N ||
              src_byte == CH_T) begin
            mode_nxt = MODE_STR;
          end else begin
            // Located just past the escape byte
            ev_a       = 1'b1;
            tok_a      = mk(TK_INVALID, CAUSE_BAD_ESC, al_o, ac_o, ao_o, '0);
            halted_nxt = 1'b1;
            mode_nxt   = MODE_IDLE;
          end
        end
        MODE_AMP, MODE_PIPE: begin
          ev_a = 1'b1;
          if ((mode_r == MODE_AMP && src_byte == CH_AMP) ||
              (mode_r == MODE_PIPE && src_byte == CH_PIPE)) begin
            tok_len_nxt = LEN_BITS'(2);
            tok_a       = mk((mode_r == MODE_AMP) ? TK_ANDAND : TK_OROR, CAUSE_NONE,
                             tl_o, tc_o, to_o, LEN_W'(2));
            mode_nxt    = MODE_IDLE;
            do_adv      = 1'b1;
          end else begin
            // Lone & or |: drop the byte that follows
            tok_a      = mk(TK_INVALID, CAUSE_BAD_CHAR, tl_o, tc_o, to_o, '0);
            halted_nxt = 1'b1;
            mode_nxt   = MODE_IDLE;
          end
        end
        MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
          ev_a = 1'b1;
          if (src_byte == CH_EQ) begin
            tok_len_nxt = LEN_BITS'(2);
            mode_nxt    = MODE_IDLE;
            do_adv      = 1'b1;
            case (mode_r)
              MODE_EQ:   tok_a = mk(TK_EQEQ, CAUSE_NONE, tl_o, tc_o, to_o, LEN_W'(2));
              MODE_BANG: tok_a = mk(TK_NE,   CAUSE_NONE, tl_o, tc_o, to_o, LEN_W'(2));
              MODE_LT:   tok_a = mk(TK_LE,   CAUSE_NONE, tl_o, tc_o, to_o, LEN_W'(2));
              default:   tok_a = mk(TK_GE,   CAUSE_NONE, tl_o, tc_o, to_o, LEN_W'(2));
            endcase
          end else begin
            do_begin = 1'b1;
            case (mode_r)
              MODE_EQ:   tok_a = mk(TK_ASSIGN, CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
              MODE_BANG: tok_a = mk(TK_BANG,   CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
              MODE_LT:   tok_a = mk(TK_LT,     CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
              default:   tok_a = mk(TK_GT,     CAUSE_NONE, tl_o, tc_o, to_o, tn_o);
            endcase
          end
        end
        default: do_begin = 1'b1;
      endcase

      if (do_begin) begin
        tok_line_nxt = cur_line_r;
        tok_col_nxt  = cur_col_r;
        tok_off_nxt  = cur_off_r;
        tok_len_nxt  = LEN_BITS'(1);
        mode_nxt     = beg_mode;
        if (beg_mode == MODE_WORD) prefix_nxt = {40'b0, src_byte};
        if (beg_err) halted_nxt = 1'b1;
        ev_b   = beg_emit;
        tok_b  = beg_tok;
        do_adv = 1'b1;
      end

      if (do_adv) begin
        cur_line_nxt = adv_line;
        cur_col_nxt  = adv_col;
        cur_off_nxt  = adv_off;
      end
    end

    if (ev_a) begin
      res.v0 = 1'b1;
      res.t0 = tok_a;
      res.v1 = ev_b;
      res.t1 = tok_b;
    end else begin
      res.v0 = ev_b;
      res.t0 = tok_b;
      res.v1 = 1'b0;
      res.t1 = tok_b;
    end
    res.t0.last = !res.v1;
    res.t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BOM0;
      cur_line_r <= LINE_BITS'(1);
      cur_col_r  <= COL_BITS'(1);
      cur_off_r  <= '0;
      tok_line_r <= LINE_BITS'(1);
      tok_col_r  <= COL_BITS'(1);
      tok_off_r  <= '0;
      tok_len_r  <= '0;
      prefix_r   <= '0;
      halted_r   <= 1'b0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_off_r  <= cur_off_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_off_r  <= tok_off_nxt;
      tok_len_r  <= tok_len_nxt;
      prefix_r   <= prefix_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

[hw/rtl/stl_fifo.sv]
// Four-entry result queue taking up to two tokens per cycle.
module stl_fifo import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  step_res_t push,
  input  logic      pop,
  output tok_t      head,
  output logic      not_empty,
  output logic      room2
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic [AW:0]   n_push;

  assign n_push = (push_en && push.v0) ? (push.v1 ? (AW+1)'(2) : (AW+1)'(1)) : '0;

  always_ff @(posedge clk) begin
    if (push_en && push.v0) mem[wr_ptr_r] <= push.t0;
    if (push_en && push.v1) mem[wr_ptr_r + AW'(1)] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push[AW-1:0];
      rd_ptr_r <= rd_ptr_r + AW'(pop);
      cnt_r    <= cnt_r + n_push - (AW+1)'(pop);
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  // Pops in the same cycle are not counted
  assign room2     = (cnt_r <= (AW+1)'(DEPTH - 2));

endmodule

[hw/rtl/script_token_lexer.sv]
// Top level of the script token lexer: input register, lexer core, result queue.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_req_type, in_src_byte
//   out_     output     out_valid / out_ready token fields, out_last_of_run
//
// A byte is registered on accept and stepped through the lexer once the queue has
// room for two tokens; the tokens it yields are registered in the result queue.
// One item per cycle when not stalled; an item with two tokens holds two slots of
// the four-entry result queue, and the staged item steps only with two slots free.
// Synchronous active-low reset; no clearing pass.
// A stalled output side fills the queue, then drops in_ready.
module script_token_lexer import stl_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 24,
  parameter int LEN_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_src_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_token_kind,
  output logic [CAUSE_W-1:0] out_error_cause,
  output logic [LINE_W-1:0]  out_start_line,
  output logic [COL_W-1:0]   out_start_column,
  output logic [OFF_W-1:0]   out_start_offset,
  output logic [LEN_W-1:0]   out_token_length,
  output logic               out_last_of_run
);

  logic       stage_v_r;
  logic       req_r;
  logic [7:0] byte_r;
  logic       room2;
  logic       step_en;
  step_res_t  res;
  tok_t       head;

  assign step_en  = stage_v_r && room2;
  assign in_ready = !stage_v_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      byte_r <= in_src_byte;
    end
  end

  stl_core #(
    .LINE_BITS   (LINE_BITS),
    .COL_BITS    (COL_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_BITS    (LEN_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .req_type (req_r),
    .src_byte (byte_r),
    .res      (res)
  );

  stl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (step_en),
    .push      (res),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_token_kind   = head.kind;
  assign out_error_cause  = head.cause;
  assign out_start_line   = head.line;
  assign out_start_column = head.col;
  assign out_start_offset = head.off;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last;

`ifndef ASSERT_OFF
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == TK_END) |-> out_last_of_run)
    else $error("End token not last of its run");

  a_cause_iff_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_token_kind == TK_INVALID) == (out_error_cause != CAUSE_NONE)))
    else $error("error cause does not match token kind");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == TK_END || out_token_kind == TK_INVALID))
      |-> (out_token_length == '0))
    else $error("End or Invalid token with nonzero length");

  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && !room2) |=> stage_v_r)
    else $error("staged item lost while queue was full");
`endif

endmodule
